// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the base64 codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Concurrent assertion that is switched off while reset is asserted.
`define B64C_ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is checked at every rising clock edge, in reset too.
`define B64C_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define B64C_ASSERT_RST(label, clk, rstn, prop, msg)
`define B64C_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/b64c_pkg.sv -----
// Package with the types, constants and alphabet functions of the base64 codec.
`default_nettype none

package b64c_pkg;

  localparam int unsigned PADDR_W  = 2;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned GRP_MAX  = 4;

  localparam logic [PADDR_W-1:0] ADDR_MODE = 2'd0;

  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } b64c_mode_e;

  // Results caused by one input transaction, held until all are sent.
  typedef struct packed {
    logic [2:0]            cnt;
    logic [GRP_MAX-1:0][7:0] data;
    logic [GRP_MAX-1:0]    dvalid;
    logic [GRP_MAX-1:0]    last;
  } b64c_grp_t;

  // Status of the result queue as seen by the top level.
  typedef struct packed {
    logic [2:0] remaining;
    logic       can_load;
  } b64c_qstat_t;

  function automatic logic [7:0] sym_to_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'(CHAR_UA + {2'b00, v});
    end else if (v < 6'd52) begin
      r = 8'(CHAR_LA + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      r = 8'(CHAR_D0 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      r = CHAR_PLUS;
    end else begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

  // Characters outside the alphabet decode as 63.
  function automatic logic [5:0] char_to_sym(input logic [7:0] ch);
    logic [5:0] r;
    if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
      r = 6'(ch - CHAR_UA);
    end else if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
      r = 6'(ch - CHAR_LA + 8'd26);
    end else if (ch >= CHAR_D0 && ch <= CHAR_D9) begin
      r = 6'(ch - CHAR_D0 + 8'd52);
    end else if (ch == CHAR_PLUS) begin
      r = 6'd62;
    end else begin
      r = 6'd63;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/b64c_step.sv -----
// Stream state and the single-pass logic that turns one input item into a result group.
`default_nettype none

module b64c_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64c_pkg::b64c_mode_e mode_i,
  input  logic               clear_i,
  input  logic               accept_i,
  input  logic [7:0]         data_in_i,
  input  logic               last_in_i,
  output b64c_pkg::b64c_grp_t grp_o
);
  import b64c_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [7:0] carry_q, carry_d;
  logic       ended_q, ended_d;
  logic [2:0] n;
  logic [5:0] v;

  always_comb begin
    grp_o   = '0;
    phase_d = phase_q;
    carry_d = carry_q;
    ended_d = ended_q;
    n       = 3'd0;
    v       = char_to_sym(data_in_i);

    if (mode_i == MODE_ENC) begin
      case (phase_q)
        2'd1: begin
          grp_o.data[0] = sym_to_char({carry_q[1:0], data_in_i[7:4]});
          carry_d       = {4'b0000, data_in_i[3:0]};
          phase_d       = 2'd2;
          n             = 3'd1;
          if (last_in_i) begin
            grp_o.data[1] = sym_to_char({data_in_i[3:0], 2'b00});
            grp_o.data[2] = CHAR_EQ;
            n             = 3'd3;
          end
        end
        2'd2: begin
          grp_o.data[0] = sym_to_char({carry_q[3:0], data_in_i[7:6]});
          grp_o.data[1] = sym_to_char(data_in_i[5:0]);
          carry_d       = 8'd0;
          phase_d       = 2'd0;
          n             = 3'd2;
        end
        default: begin
          // Phase three never occurs when encoding and acts as phase zero.
          grp_o.data[0] = sym_to_char(data_in_i[7:2]);
          carry_d       = {6'b000000, data_in_i[1:0]};
          phase_d       = 2'd1;
          n             = 3'd1;
          if (last_in_i) begin
            grp_o.data[1] = sym_to_char({data_in_i[1:0], 4'b0000});
            grp_o.data[2] = CHAR_EQ;
            grp_o.data[3] = CHAR_EQ;
            n             = 3'd4;
          end
        end
      endcase
    end else if (!ended_q && data_in_i != CHAR_NL) begin
      if (data_in_i == CHAR_EQ) begin
        ended_d = 1'b1;
      end else begin
        case (phase_q)
          2'd0: begin
            carry_d = {v, 2'b00};
          end
          2'd1: begin
            grp_o.data[0] = carry_q | {6'b000000, v[5:4]};
            carry_d       = {v[3:0], 4'b0000};
            n             = 3'd1;
          end
          2'd2: begin
            grp_o.data[0] = carry_q | {4'b0000, v[5:2]};
            carry_d       = {v[1:0], 6'b000000};
            n             = 3'd1;
          end
          default: begin
            grp_o.data[0] = carry_q | {2'b00, v};
            carry_d       = 8'd0;
            n             = 3'd1;
          end
        endcase
        phase_d = 2'(phase_q + 2'd1);
      end
    end

    for (int i = 0; i < GRP_MAX; i++) begin
      grp_o.dvalid[i] = (3'(i) < n);
    end

    if (last_in_i) begin
      // A final item that yields nothing still ends the stream with an empty marker.
      if (n == 3'd0) begin
        n = 3'd1;
      end
      grp_o.last[2'(n - 3'd1)] = 1'b1;
      phase_d = 2'd0;
      carry_d = 8'd0;
      ended_d = 1'b0;
    end
    grp_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      carry_q <= 8'd0;
      ended_q <= 1'b0;
    end else if (clear_i) begin
      phase_q <= 2'd0;
      carry_q <= 8'd0;
      ended_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64c_outq.sv -----
// Result register that holds one group and sends its entries one per cycle while the output is not stalled.
`default_nettype none

module b64c_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  b64c_pkg::b64c_grp_t grp_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          data_out_o,
  output logic                data_valid_o,
  output logic                last_out_o,
  output b64c_pkg::b64c_qstat_t stat_o
);
  import b64c_pkg::*;

  b64c_grp_t  grp_q;
  logic [2:0] rem_q;
  logic [1:0] idx_q;
  logic       take;

  assign out_valid_o  = (rem_q != 3'd0);
  assign take         = out_valid_o && !out_stall_i;
  assign data_out_o   = grp_q.data[idx_q];
  assign data_valid_o = grp_q.dvalid[idx_q];
  assign last_out_o   = grp_q.last[idx_q];

  // A new group may enter as the last entry of the current one leaves.
  assign stat_o.remaining = rem_q;
  assign stat_o.can_load  = (rem_q == 3'd0) || (rem_q == 3'd1 && take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= grp_i.cnt;
      idx_q <= 2'd0;
    end else if (take) begin
      rem_q <= rem_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_codec.sv -----
// Top level of the streaming base64 codec: configuration port, state logic and result queue.
//
//   channel  direction  handshake                  payload
//   input    in         in_valid_i / in_stall_o    data_in_i, last_in_i
//   output   out        out_valid_o / out_stall_i  data_out_o, data_valid_o, last_out_o
//   config   in         APB write, pready high     mode at byte address 0
//
// An input item is processed in the cycle it is accepted and its results appear the next cycle.
// The single output port sends one result per cycle while out_stall_i is low, so an item causing
// several results holds the input side until its last result leaves; a byte causes up to two, a final byte up to four.
// Reset clears the mode to encode and the stream state; there is no clearing pass.
// An output stall holds the current result and stalls the input once the queue is full.
`default_nettype none
`include "assert_macros.svh"

module base64_stream_codec (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [b64c_pkg::PADDR_W-1:0]  paddr,
  input  logic [b64c_pkg::PDATA_W-1:0]  pwdata,
  output logic [b64c_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_in_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    data_out_o,
  output logic                          data_valid_o,
  output logic                          last_out_o
);
  import b64c_pkg::*;

  b64c_mode_e  mode_q;
  logic        cfg_wr;
  logic        mode_wr;
  logic        in_acc;
  b64c_grp_t   grp;
  b64c_qstat_t qstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign mode_wr = cfg_wr && (paddr == ADDR_MODE);
  assign prdata  = (paddr == ADDR_MODE) ? {{(PDATA_W-1){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENC;
    end else if (mode_wr) begin
      mode_q <= b64c_mode_e'(pwdata[0]);
    end
  end

  assign in_stall_o = !qstat.can_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  b64c_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .clear_i   (mode_wr),
    .accept_i  (in_acc),
    .data_in_i (data_in_i),
    .last_in_i (last_in_i),
    .grp_o     (grp)
  );

  b64c_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_acc && (grp.cnt != 3'd0)),
    .grp_i        (grp),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .data_out_o   (data_out_o),
    .data_valid_o (data_valid_o),
    .last_out_o   (last_out_o),
    .stat_o       (qstat)
  );

  // With more than one result still queued there is no room for another group.
  `B64C_ASSERT_RST(a_stall_when_busy, clk_i, rst_ni, (qstat.remaining > 3'd1) |-> in_stall_o, "input not stalled while results are queued")
  // The final item of a stream always produces at least one result.
  `B64C_ASSERT_RST(a_last_gives_result, clk_i, rst_ni, (in_acc && last_in_i) |=> out_valid_o, "final transaction produced no result")
  // An empty result is only ever the end-of-stream marker.
  `B64C_ASSERT_RST(a_empty_is_last, clk_i, rst_ni, (out_valid_o && !data_valid_o) |-> last_out_o, "empty result without last flag")

endmodule

`default_nettype wire
